/* design/ctpo_pkg.sv */
package ctpo_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;

	localparam logic [3:0] DIV_10MS  = 4'd10;
	localparam logic [3:0] DIV_100MS = 4'd10;
	localparam logic [2:0] DIV_500MS = 3'd5;
	localparam logic [1:0] DIV_1S    = 2'd2;
	localparam logic [1:0] FIRST_1S  = 2'd1;

	typedef struct packed {
		logic ok;
		logic pulse_10ms;
		logic pulse_100ms;
		logic pulse_500ms;
		logic pulse_1s;
	} ctpo_result_t;

	typedef struct packed {
		logic       pulse;
		logic [3:0] value;
	} stage_step_t;

	// Count down by one; reload and pulse on reaching zero.
	function automatic stage_step_t stage_step(input logic [3:0] value,
			input logic [3:0] reload);
		stage_step_t r;
		logic [3:0]  v;
		v = (value == 4'd0) ? 4'd0 : value - 4'd1;
		if (v == 4'd0) begin
			r.pulse = 1'b1;
			r.value = reload;
		end else begin
			r.pulse = 1'b0;
			r.value = v;
		end
		return r;
	endfunction

endpackage

/* design/ctpo_if.sv */
interface ctpo_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  timer_id;
	logic [15:0] length;

	modport source (output valid, op, timer_id, length, input ready);
	modport sink   (input valid, op, timer_id, length, output ready);
endinterface

interface ctpo_rsp_if;
	logic valid;
	logic ready;
	logic ok;
	logic pulse_10ms;
	logic pulse_100ms;
	logic pulse_500ms;
	logic pulse_1s;

	modport source (output valid, ok, pulse_10ms, pulse_100ms, pulse_500ms, pulse_1s,
		input ready);
	modport sink   (input valid, ok, pulse_10ms, pulse_100ms, pulse_500ms, pulse_1s,
		output ready);
endinterface

/* design/cascaded_tick_prescaler_oneshots_core.sv */
// Channel  Dir  Payload                                            Role
// req      in   op, timer_id, length                               tick / set / poll
// rsp      out  ok, pulse_10ms, pulse_100ms, pulse_500ms, pulse_1s one result each
//
// One transaction per clock while req.ready is high: a request updates the
// prescaler and timers in the cycle it is accepted, and its result reaches the
// output register next cycle, or the skid register while an earlier result waits in front.
// A two-entry output (result register plus skid register) lets a request be
// taken while a finished result waits; req.ready drops only when both are full.
// Reset puts the prescaler at 10/10/5/1 and clears and disarms all timers.
module cascaded_tick_prescaler_oneshots_core
	import ctpo_pkg::*;
#(
	parameter int TIMER_BITS = 16,
	parameter int NUM_TIMERS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	ctpo_req_if.sink   req,
	ctpo_rsp_if.source rsp
);

	localparam int IDX_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [3:0] ms_stage_q;
	logic [3:0] tens_stage_q;
	logic [2:0] fives_stage_q;
	logic [1:0] halves_stage_q;
	logic [TIMER_BITS-1:0] timer_value_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] timer_armed_q;

	ctpo_result_t out_q, skid_q, res;
	logic         out_v_q, skid_v_q;

	logic                  accept, pop, id_valid, expired;
	logic [IDX_BITS-1:0]   idx;
	logic [TIMER_BITS-1:0] len_t;
	stage_step_t           st_ms, st_tens, st_fives, st_halves;

	assign req.ready = !skid_v_q;
	assign accept    = req.valid && req.ready;
	assign pop       = out_v_q && rsp.ready;

	assign id_valid = 32'(req.timer_id) < NUM_TIMERS;
	assign idx      = req.timer_id[IDX_BITS-1:0];
	assign len_t    = TIMER_BITS'(32'(req.length));
	assign expired  = id_valid && timer_armed_q[idx] && (timer_value_q[idx] == '0);

	assign st_ms     = stage_step(ms_stage_q, DIV_10MS);
	assign st_tens   = stage_step(tens_stage_q, DIV_100MS);
	assign st_fives  = stage_step({1'b0, fives_stage_q}, {1'b0, DIV_500MS});
	assign st_halves = stage_step({2'b00, halves_stage_q}, {2'b00, DIV_1S});

	always_comb begin
		res = '0;
		unique case (req.op)
			OP_TICK: begin
				res.pulse_10ms  = st_ms.pulse;
				res.pulse_100ms = st_ms.pulse && st_tens.pulse;
				res.pulse_500ms = res.pulse_100ms && st_fives.pulse;
				res.pulse_1s    = res.pulse_500ms && st_halves.pulse;
			end
			OP_SET:  res.ok = id_valid;
			OP_POLL: res.ok = expired;
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_stage_q     <= DIV_10MS;
			tens_stage_q   <= DIV_100MS;
			fives_stage_q  <= DIV_500MS;
			halves_stage_q <= FIRST_1S;
			timer_armed_q  <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				timer_value_q[i] <= '0;
			end
		end else if (accept) begin
			if (req.op == OP_TICK) begin
				ms_stage_q <= st_ms.value;
				if (st_ms.pulse) begin
					tens_stage_q <= st_tens.value;
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (timer_value_q[i] != '0) begin
							timer_value_q[i] <= timer_value_q[i] - TIMER_BITS'(1);
						end
					end
					if (st_tens.pulse) begin
						fives_stage_q <= st_fives.value[2:0];
						if (st_fives.pulse) begin
							halves_stage_q <= st_halves.value[1:0];
						end
					end
				end
			end else if (req.op == OP_SET && id_valid) begin
				timer_value_q[idx] <= len_t;
				timer_armed_q[idx] <= (len_t != '0);
			end else if (req.op == OP_POLL && expired) begin
				timer_armed_q[idx] <= 1'b0;
			end
		end
	end

	// Result register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_v_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.ok          = out_q.ok;
	assign rsp.pulse_10ms  = out_q.pulse_10ms;
	assign rsp.pulse_100ms = out_q.pulse_100ms;
	assign rsp.pulse_500ms = out_q.pulse_500ms;
	assign rsp.pulse_1s    = out_q.pulse_1s;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a result in front");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ms_stage_q != 4'd0) && (ms_stage_q <= DIV_10MS))
		else $error("10 ms stage out of range");

	a_pulse_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.pulse_1s) |-> (out_q.pulse_500ms && out_q.pulse_100ms
			&& out_q.pulse_10ms))
		else $error("1 s pulse without the faster pulses");

	a_ok_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.ok) |-> !out_q.pulse_10ms)
		else $error("ok and 10 ms pulse in one result");

	a_set_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_SET && id_valid && len_t != '0)
			|=> timer_armed_q[$past(idx)])
		else $error("set with nonzero length left the timer disarmed");

endmodule
